FILE: rtl/modexp_pkg.sv
package modexp_pkg;

   // Word width of base, exponent, modulus and result.
   localparam int WORD_BITS = 32;

   // Stream payload widths, rounded up to whole bytes.
   localparam int REQ_DATA_BITS = ((3 * WORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((WORD_BITS + 7) / 8) * 8;

   // Bit counter of the serial multiplier.
   localparam int CNT_BITS = $clog2(WORD_BITS);

   // Sequencer state codes.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_REDUCE = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_SQR    = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   // Command to the shared multiply-reduce unit.
   typedef struct packed {
      logic                 start;
      logic [WORD_BITS-1:0] x;
      logic [WORD_BITS-1:0] y;
      logic [WORD_BITS-1:0] n;
   } mm_req_type;

   // Status and result of the shared multiply-reduce unit.
   typedef struct packed {
      logic                 done;
      logic [WORD_BITS-1:0] product;
   } mm_rsp_type;

   // Modular addition of two residues below n.
   function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] a,
                                                    input logic [WORD_BITS-1:0] b,
                                                    input logic [WORD_BITS-1:0] n);
      logic [WORD_BITS:0] sum;
      logic [WORD_BITS:0] diff;
      sum  = {1'b0, a} + {1'b0, b};
      diff = sum - {1'b0, n};
      if (sum >= {1'b0, n}) begin
         return diff[WORD_BITS-1:0];
      end
      return sum[WORD_BITS-1:0];
   endfunction

endpackage

FILE: rtl/modexp_mulmod.sv
// Serial multiply-reduce unit: product = (x * y) mod n for x below n and any y.
// One multiplier bit per cycle, least significant first, for all WORD_BITS bits.
module modexp_mulmod (
   input  logic                   clock,
   input  logic                   reset,
   input  modexp_pkg::mm_req_type mm_req,
   output modexp_pkg::mm_rsp_type mm_rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [modexp_pkg::CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [modexp_pkg::WORD_BITS-1:0]    acc_ff, acc_in;
   logic [modexp_pkg::WORD_BITS-1:0]    addend_ff, addend_in;
   logic [modexp_pkg::WORD_BITS-1:0]    mult_ff, mult_in;
   logic [modexp_pkg::WORD_BITS-1:0]    n_ff, n_in;

   localparam logic [modexp_pkg::CNT_BITS-1:0] LAST_CNT =
      modexp_pkg::CNT_BITS'(modexp_pkg::WORD_BITS - 1);

   // Accumulate and double in parallel; each path is one add and compare.
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      addend_in = addend_ff;
      mult_in   = mult_ff;
      n_in      = n_ff;
      if (mm_req.start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         addend_in = mm_req.x;
         mult_in   = mm_req.y;
         n_in      = mm_req.n;
      end else if (busy_ff) begin
         if (mult_ff[0]) begin
            acc_in = modexp_pkg::add_mod(acc_ff, addend_ff, n_ff);
         end
         addend_in = modexp_pkg::add_mod(addend_ff, addend_ff, n_ff);
         mult_in   = mult_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      addend_ff <= addend_in;
      mult_ff   <= mult_in;
      n_ff      <= n_in;
   end

   assign mm_rsp.done    = done_ff;
   assign mm_rsp.product = acc_ff;

endmodule

FILE: rtl/modular_exponentiation.sv
// Modular exponentiation, right-to-left binary method.
// The request channel carries base, exponent and modulus; each transfer
// yields exactly one response transfer with base^exponent mod modulus in
// rsp_tdata and a bad-modulus flag in rsp_tuser.
// A zero modulus answers 0 with the flag set; a zero exponent answers 1.
// Zero modulus or zero exponent go from idle straight to the done state.
// Otherwise one multiply-reduce reduces the base, then each exponent bit
// up to the highest set one costs a square, plus a multiply when the bit
// is one, and the result then passes through the done state. All of it
// runs on the one serial multiply-reduce unit, which handles a single
// multiplier bit per cycle.
// req_tready is high only while the sequencer is idle, so one item is in
// work at a time. A finished result moves to an output register; a new
// request is taken while that result waits for rsp_tready. If the receiver
// still holds the previous result, the finished one waits in the sequencer.
// Synchronous reset empties the output register and returns to idle.
module modular_exponentiation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: base, exponent, modulus.
   input  logic [modexp_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: power_result.
   output logic [modexp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // Fields from bit 0: bad_modulus.
   output logic [0:0]                           rsp_tuser
);

   localparam int W = modexp_pkg::WORD_BITS;

   logic [2:0]   state_ff, state_in;
   logic         issued_ff, issued_in;
   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] exp_ff, exp_in;
   logic [W-1:0] mod_ff, mod_in;
   logic [W-1:0] res_ff, res_in;
   logic         bad_ff, bad_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_data_ff, rsp_data_in;
   logic         rsp_bad_ff, rsp_bad_in;

   logic         req_xfer;
   logic         out_free;
   logic [W-1:0] in_base, in_exp, in_mod;
   logic [W-1:0] exp_next;

   modexp_pkg::mm_req_type mm_req;
   modexp_pkg::mm_rsp_type mm_rsp;

   modexp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   assign in_base  = req_tdata[W-1:0];
   assign in_exp   = req_tdata[2*W-1:W];
   assign in_mod   = req_tdata[3*W-1:2*W];
   assign req_tready = (state_ff == modexp_pkg::S_IDLE);
   assign req_xfer = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign exp_next = exp_ff >> 1;

   // Operand selection for the shared unit, one command per working state.
   always_comb begin
      mm_req.start = 1'b0;
      mm_req.x     = base_ff;
      mm_req.y     = base_ff;
      mm_req.n     = mod_ff;
      unique case (state_ff)
         modexp_pkg::S_REDUCE: begin
            mm_req.start = !issued_ff;
            mm_req.x     = res_ff;
         end
         modexp_pkg::S_MUL: begin
            mm_req.start = !issued_ff;
            mm_req.y     = res_ff;
         end
         modexp_pkg::S_SQR: begin
            mm_req.start = !issued_ff;
         end
         default: begin
            mm_req.start = 1'b0;
         end
      endcase
   end

   // Sequencer over the exponent bits.
   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      res_in       = res_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (mm_req.start) begin
         issued_in = 1'b1;
      end
      unique case (state_ff)
         modexp_pkg::S_IDLE: begin
            if (req_xfer) begin
               base_in = in_base;
               exp_in  = in_exp;
               mod_in  = in_mod;
               bad_in  = 1'b0;
               if (in_mod == '0) begin
                  res_in   = '0;
                  bad_in   = 1'b1;
                  state_in = modexp_pkg::S_DONE;
               end else if (in_exp == '0) begin
                  res_in   = W'(1);
                  state_in = modexp_pkg::S_DONE;
               end else begin
                  // Start from one reduced modulo n; it also reduces the base.
                  res_in   = (in_mod == W'(1)) ? '0 : W'(1);
                  state_in = modexp_pkg::S_REDUCE;
               end
            end
         end
         modexp_pkg::S_REDUCE: begin
            if (mm_rsp.done) begin
               issued_in = 1'b0;
               base_in   = mm_rsp.product;
               state_in  = exp_ff[0] ? modexp_pkg::S_MUL : modexp_pkg::S_SQR;
            end
         end
         modexp_pkg::S_MUL: begin
            if (mm_rsp.done) begin
               issued_in = 1'b0;
               res_in    = mm_rsp.product;
               state_in  = modexp_pkg::S_SQR;
            end
         end
         modexp_pkg::S_SQR: begin
            if (mm_rsp.done) begin
               issued_in = 1'b0;
               base_in   = mm_rsp.product;
               exp_in    = exp_next;
               if (exp_next == '0) begin
                  state_in = modexp_pkg::S_DONE;
               end else begin
                  state_in = exp_next[0] ? modexp_pkg::S_MUL : modexp_pkg::S_SQR;
               end
            end
         end
         modexp_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_bad_in   = bad_ff;
               state_in     = modexp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = modexp_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= modexp_pkg::S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      mod_ff      <= mod_in;
      res_ff      <= res_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = modexp_pkg::RSP_DATA_BITS'(rsp_data_ff);
   assign rsp_tuser[0] = rsp_bad_ff;

endmodule

FILE: rtl/modexp_checker.sv
// Port-level checks for the modular exponentiation block.
module modexp_port_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [modexp_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [modexp_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [0:0]                           rsp_tuser
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // One item at a time: the block is busy right after a request transfer.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in work");

   // A flagged modulus always comes with a zero result.
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("bad modulus with nonzero result");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // The request field is only observed through the transfer checks.
   logic [modexp_pkg::WORD_BITS-1:0] req_mod_seen;
   assign req_mod_seen = req_tdata[3*modexp_pkg::WORD_BITS-1:2*modexp_pkg::WORD_BITS];

   // A zero modulus is answered with the flag once the output is free.
   a_zero_mod_flag: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_mod_seen == '0) && !rsp_tvalid
      |=> ##1 rsp_tvalid && rsp_tuser[0])
      else $error("zero modulus not flagged");

endmodule

bind modular_exponentiation modexp_port_checker u_modexp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: dv/modexp_checker.sv
// Watches both stream channels of the modular exponentiation block.
// Each request transfer is turned into an expected power, and each
// response transfer is compared with the oldest one still waiting.
module modexp_checker
   import modexp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   // Fields from bit 0: base, exponent, modulus.
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // Fields from bit 0: power_result.
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // Fields from bit 0: bad_modulus.
   input  logic [0:0]               rsp_tuser,
   output int                       mismatch_count,
   output int                       results_checked,
   output int                       powers_outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = WORD_BITS;

   typedef struct packed {
      logic [W-1:0] power_result;
      logic         bad_modulus;
   } power_type;

   // Expected results, oldest first.
   power_type expected_powers[$];

   // Right-to-left square and multiply with exact double-width products.
   function automatic power_type predict_power(input logic [W-1:0] base,
                                               input logic [W-1:0] exponent,
                                               input logic [W-1:0] modulus);
      logic [2*W-1:0] product;
      logic [W-1:0]   running;
      logic [W-1:0]   squared;
      logic [W-1:0]   bits_left;
      power_type      answer;
      answer.power_result = '0;
      answer.bad_modulus  = 1'b1;
      if (modulus == '0) begin
         return answer;
      end
      // A zero exponent leaves the running value at 1, unreduced.
      running   = W'(1);
      squared   = base;
      bits_left = exponent;
      while (bits_left != '0) begin
         if (bits_left[0]) begin
            product = {{W{1'b0}}, running} * {{W{1'b0}}, squared};
            running = W'(product % {{W{1'b0}}, modulus});
         end
         product   = {{W{1'b0}}, squared} * {{W{1'b0}}, squared};
         squared   = W'(product % {{W{1'b0}}, modulus});
         bits_left = bits_left >> 1;
      end
      answer.power_result = running;
      answer.bad_modulus  = 1'b0;
      return answer;
   endfunction

   initial begin
      mismatch_count     = 0;
      results_checked    = 0;
      powers_outstanding = 0;
   end

   // Responses are handled before requests, so a response never meets
   // the expectation of a request taken in the same cycle.
   always @(posedge clock) begin : monitor
      power_type expected_power;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_powers.size() == 0) begin
               $error("result transfer with nothing expected: power_result %h bad_modulus %b",
                      rsp_tdata[W-1:0], rsp_tuser[0]);
               mismatch_count++;
            end else begin
               expected_power = expected_powers.pop_front();
               if (rsp_tdata[W-1:0] !== expected_power.power_result) begin
                  $error("power_result: expected %h, actual %h",
                         expected_power.power_result, rsp_tdata[W-1:0]);
                  mismatch_count++;
               end
               if (rsp_tuser[0] !== expected_power.bad_modulus) begin
                  $error("bad_modulus: expected %b, actual %b",
                         expected_power.bad_modulus, rsp_tuser[0]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_powers.push_back(predict_power(req_tdata[W-1:0],
                                                    req_tdata[2*W-1:W],
                                                    req_tdata[3*W-1:2*W]));
         end
      end
      powers_outstanding = expected_powers.size();
   end

endmodule

FILE: dv/modular_exponentiation_tb.sv
// Drives requests into the modular exponentiation block and a ready
// pattern on its response side; the checker does all of the comparing.
module modular_exponentiation_tb;

   import modexp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int W                = WORD_BITS;
   localparam int RANDOM_ITEMS     = 280;
   localparam int LONG_HOLD_CYCLES = 4000;
   localparam int END_CYCLES       = 100;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   // Fields from bit 0: base, exponent, modulus.
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   // Fields from bit 0: power_result.
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   // Fields from bit 0: bad_modulus.
   logic [0:0]               rsp_tuser;

   int mismatch_count;
   int results_checked;
   int powers_outstanding;

   // Stimulus controls shared between the sender and the receiver.
   bit quiet_sender;
   bit quiet_receiver;
   bit long_hold_due;

   int requests_sent;
   int zero_modulus_sent;
   int zero_exponent_sent;
   int wide_exponent_sent;

   modular_exponentiation i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   modexp_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser),
      .mismatch_count     (mismatch_count),
      .results_checked    (results_checked),
      .powers_outstanding (powers_outstanding)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   // Offers one request after a random gap and returns at the falling edge
   // after its transfer, with req_tvalid still high.
   task automatic send_request(input logic [W-1:0] base,
                               input logic [W-1:0] exponent,
                               input logic [W-1:0] modulus);
      int                       gap;
      logic [REQ_DATA_BITS-1:0] payload;
      gap = quiet_sender ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      payload          = '0;
      payload[3*W-1:0] = {modulus, exponent, base};
      req_tvalid <= 1'b1;
      req_tdata  <= payload;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      requests_sent++;
      if (modulus == '0) zero_modulus_sent++;
      if (exponent == '0) zero_exponent_sent++;
      if (exponent[W-1:8] != '0) wide_exponent_sent++;
   endtask

   // Random request; most exponents are short to keep the run fast.
   task automatic send_random_request(input bit short_exponent);
      logic [W-1:0] base;
      logic [W-1:0] exponent;
      logic [W-1:0] modulus;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) base = $urandom;
      else if (pick < 85) base = $urandom_range(0, 3);
      else base = ~W'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 8) exponent = '0;
      else if (pick < 75 || short_exponent) exponent = $urandom_range(1, 255);
      else exponent = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 5) modulus = '0;
      else if (pick < 15) modulus = $urandom_range(1, 4);
      else if (pick < 30) modulus = ~W'($urandom_range(0, 8));
      else if (pick < 50) modulus = $urandom >> $urandom_range(1, W - 1);
      else modulus = $urandom;
      send_request(base, exponent, modulus);
   endtask

   // Stops offering and waits until every expected result has arrived.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (powers_outstanding == 0);
      @(negedge clock);
   endtask

   // Receiver: a random stall before each result, or one long hold when asked.
   initial begin : receiver
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end else if (quiet_receiver) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 8);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      quiet_sender       = 1'b0;
      quiet_receiver     = 1'b0;
      long_hold_due      = 1'b0;
      requests_sent      = 0;
      zero_modulus_sent  = 0;
      zero_exponent_sent = 0;
      wide_exponent_sent = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, zero modulus, zero exponent, base at or
      // above the modulus, a modulus of one and single-bit exponents.
      send_request(32'd2, 32'd10, 32'd1000);
      send_request(32'd0, 32'd0, 32'd0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      send_request(32'd5, 32'd0, 32'd1);
      send_request(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      send_request(32'd0, 32'd5, 32'd7);
      send_request(32'd0, 32'd0, 32'd7);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
      send_request(32'd3, 32'h8000_0000, 32'hFFFF_FFFB);
      send_request(32'd7, 32'd1, 32'd5);
      send_request(32'd123456789, 32'd1, 32'hFFFF_FFFF);
      send_request(32'd2, 32'd31, 32'h8000_0000);
      send_request(32'd2, 32'd31, 32'hFFFF_FFFF);
      send_request(32'd12345, 32'd65537, 32'd1);
      send_request(32'd1, 32'hFFFF_FFFF, 32'd2);
      send_request(32'hDEAD_BEEF, 32'hAAAA_AAAA, 32'h5555_5555);
      send_request(32'h1234_5678, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(32'h8000_0000, 32'd2, 32'h8000_0001);
      drain_results();

      repeat (120) send_random_request(1'b0);
      drain_results();

      // Long receiver hold while requests keep coming, so the input stalls.
      long_hold_due = 1'b1;
      repeat (10) send_random_request(1'b1);
      drain_results();

      // Back-to-back stretch with no idling on either side.
      quiet_sender   = 1'b1;
      quiet_receiver = 1'b1;
      repeat (50) send_random_request(1'b0);
      quiet_sender   = 1'b0;
      quiet_receiver = 1'b0;

      repeat (RANDOM_ITEMS - 180) send_random_request(1'b0);
      req_tvalid <= 1'b0;
      wait (powers_outstanding == 0);
      repeat (END_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d with zero modulus, %0d with zero exponent,",
               requests_sent, zero_modulus_sent, zero_exponent_sent);
      $display("%0d with exponents wider than 8 bits; %0d results checked.",
               wide_exponent_sent, results_checked);
      if (mismatch_count == 0 && powers_outstanding == 0) begin
         $display("modular_exponentiation_tb passed");
      end else begin
         $display("modular_exponentiation_tb failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #40ms;
      $display("modular_exponentiation_tb failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/modexp_pkg.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation.sv
rtl/modexp_checker.sv
dv/modexp_checker.sv
dv/modular_exponentiation_tb.sv
